// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh: assertion shorthands for the curb point classifier
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre in one cycle implies post in the next; off while in reset
`define LCPC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// same, also checked while reset is asserted
`define LCPC_ASSERT_RESET(label, pre, post, msg) \
  label: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/lcpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcpc_pkg: shared types and constants of the curb point classifier
// Window geometry, datapath widths, register indexes and sequencer codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lcpc_pkg;

  localparam int MAX_HALF    = 16;
  localparam int WIN_DEPTH   = 2 * MAX_HALF + 1;
  localparam int RING_POINTS = 2048;

  localparam int COORD_W = 18;
  localparam int IDX_W   = $clog2(RING_POINTS);
  localparam int HALF_W  = $clog2(MAX_HALF + 1);
  localparam int CNT_W   = $clog2(WIN_DEPTH + 1);
  localparam int SUM_W   = COORD_W + $clog2(MAX_HALF);
  localparam int OFS_W   = SUM_W + 2;
  localparam int PROD_W  = 2 * OFS_W;

  // iterative multiplier
  localparam int MUL_A_W     = 94;
  localparam int MUL_B_W     = 47;
  localparam int MUL_P_W     = 128;
  localparam int MUL_CNT_W   = $clog2(MUL_B_W);
  localparam int ANGLE_SHIFT = 30;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CURB_POINTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_COS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURB_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_DIFF   = 3'd4;

  localparam logic [4:0]         RST_CURB_POINTS = 5'd5;
  localparam logic signed [15:0] RST_ANGLE_COS   = -16'sd25101;
  localparam logic [9:0]         RST_CURB_HEIGHT = 10'd50;
  localparam logic [15:0]        RST_SPAN_LIMIT  = 16'd5000;
  localparam logic [9:0]         RST_SIDE_DIFF   = 10'd50;

  // product schedule of the square/dot step
  localparam int SQ_W = 4;
  localparam logic [SQ_W-1:0] SQ_A_X = 4'd0;
  localparam logic [SQ_W-1:0] SQ_A_Y = 4'd1;
  localparam logic [SQ_W-1:0] SQ_B_X = 4'd2;
  localparam logic [SQ_W-1:0] SQ_B_Y = 4'd3;
  localparam logic [SQ_W-1:0] SQ_D_X = 4'd4;
  localparam logic [SQ_W-1:0] SQ_D_Y = 4'd5;
  localparam logic [SQ_W-1:0] SQ_S_X = 4'd6;
  localparam logic [SQ_W-1:0] SQ_S_Y = 4'd7;
  localparam logic [SQ_W-1:0] SQ_LIM = 4'd8;
  localparam logic [SQ_W-1:0] SQ_END = 4'd9;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_OFFSET,
    ST_SQUARE,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DECIDE
  } state_t;

  typedef enum logic [1:0] {
    MSEL_DOT,
    MSEL_AB,
    MSEL_T
  } mul_sel_t;

endpackage

`default_nettype wire

// ===== rtl/lidar_curb_point_classifier.sv =====
// ----------------------------------------------------------------------------
// lidar_curb_point_classifier: curb flag for each centre of a lidar ring
// Points of one ring come in on the in_valid/in_ready channel in azimuth
// order; first_of_ring restarts the window and the ring position. Once 2N+1
// points of the ring are held, each point transfer yields one result on the
// out_valid/out_ready channel: the ring position of the point N back and
// its curb flag. A point that completes no window leaves the block ready for
// the next point. Otherwise the window of 33 cells rotates once past the
// head, offsets and 9 products follow, then three wide products go through
// one shift-add multiplier and a decision step; in_ready stays low from
// transfer to result, so no new point is taken meanwhile. The result waits
// in an output register; a stalled receiver holds only the next decision.
// Registers are written on cfg_valid/cfg_ready (always ready); the user
// must write them only while idle, as the block does not enforce it.
// Reset (rst, synchronous) empties the window, zeroes the ring position,
// drops out_valid and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_curb_point_classifier import lcpc_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] x_mm,
  input  wire logic signed [COORD_W-1:0] y_mm,
  input  wire logic signed [COORD_W-1:0] z_mm,
  input  wire logic                      first_of_ring,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [IDX_W-1:0]               center_index,
  output logic                           is_curb,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  // configuration
  logic [4:0]         curb_points;
  logic signed [15:0] angle_cos;
  logic [9:0]         curb_height;
  logic [15:0]        span_limit;
  logic [9:0]         side_diff;
  logic [HALF_W-1:0]  half_n;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curb_points <= RST_CURB_POINTS;
      angle_cos   <= RST_ANGLE_COS;
      curb_height <= RST_CURB_HEIGHT;
      span_limit  <= RST_SPAN_LIMIT;
      side_diff   <= RST_SIDE_DIFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CURB_POINTS: curb_points <= cfg_data[4:0];
        CFG_ANGLE_COS:   angle_cos   <= $signed(cfg_data);
        CFG_CURB_HEIGHT: curb_height <= cfg_data[9:0];
        CFG_SPAN_LIMIT:  span_limit  <= cfg_data;
        CFG_SIDE_DIFF:   side_diff   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (curb_points == '0) begin
      half_n = HALF_W'(1);
    end else if (curb_points > HALF_W'(MAX_HALF)) begin
      half_n = HALF_W'(MAX_HALF);
    end else begin
      half_n = curb_points;
    end
  end

  // control
  state_t   state, state_next;
  mul_sel_t mul_sel;
  logic     in_xfer;
  logic     out_load;
  logic     mul_start;
  logic     mul_done;

  logic [IDX_W-1:0] ring_pos;
  logic [IDX_W-1:0] pos_cur;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_cur;
  logic [CNT_W-1:0] win_need;
  logic [CNT_W-1:0] step;
  logic [SQ_W-1:0]  sq_k;
  logic [IDX_W-1:0] center_q;
  logic             curb_flag;

  assign in_xfer  = in_valid && in_ready;
  assign win_need = CNT_W'({half_n, 1'b1});

  always_comb begin
    pos_cur = first_of_ring ? '0 : ring_pos;
    if (first_of_ring) begin
      fill_cur = CNT_W'(1);
    end else if (fill == CNT_W'(WIN_DEPTH)) begin
      fill_cur = fill;
    end else begin
      fill_cur = fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mul_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && fill_cur >= win_need) begin
          state_next = ST_ROT;
        end
      end
      ST_ROT: begin
        if (step == CNT_W'(WIN_DEPTH - 1)) begin
          state_next = ST_OFFSET;
        end
      end
      ST_OFFSET: state_next = ST_SQUARE;
      ST_SQUARE: begin
        if (sq_k == SQ_END) begin
          state_next = ST_MUL_GO;
        end
      end
      ST_MUL_GO: begin
        mul_start  = 1'b1;
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          state_next = (mul_sel == MSEL_T) ? ST_DECIDE : ST_MUL_GO;
        end
      end
      ST_DECIDE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pos <= '0;
      fill     <= '0;
      step     <= '0;
      sq_k     <= '0;
      mul_sel  <= MSEL_DOT;
    end else begin
      if (in_xfer) begin
        ring_pos <= pos_cur + 1'b1;
        fill     <= fill_cur;
        step     <= '0;
      end
      if (state == ST_ROT) begin
        step <= step + 1'b1;
      end
      if (state == ST_OFFSET) begin
        sq_k    <= '0;
        mul_sel <= MSEL_DOT;
      end else if (state == ST_SQUARE) begin
        sq_k <= sq_k + 1'b1;
      end
      if (state == ST_MUL_WAIT && mul_done) begin
        case (mul_sel)
          MSEL_DOT: mul_sel <= MSEL_AB;
          MSEL_AB:  mul_sel <= MSEL_T;
          default:  mul_sel <= MSEL_DOT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      center_q <= pos_cur - IDX_W'(half_n);
    end
  end

  // window: cell 0 is the head
  point_t     cell_q [WIN_DEPTH];
  point_t     in_pt;
  cell_ctrl_t cell_ctrl;

  assign in_pt            = '{x: x_mm, y: y_mm, z: z_mm};
  assign cell_ctrl.shift  = in_xfer;
  assign cell_ctrl.rotate = (state == ST_ROT);

  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      lcpc_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .shift_in (in_pt),
        .rot_in   (cell_q[1]),
        .data     (cell_q[0])
      );
    end else if (k == WIN_DEPTH - 1) begin : g_tail
      lcpc_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .shift_in (cell_q[k-1]),
        .rot_in   (cell_q[0]),
        .data     (cell_q[k])
      );
    end else begin : g_mid
      lcpc_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .shift_in (cell_q[k-1]),
        .rot_in   (cell_q[k+1]),
        .data     (cell_q[k])
      );
    end
  end

  // head accumulation: at rotation step t the head holds the point t back
  point_t                    head;
  logic [COORD_W-1:0]        head_zabs;
  logic [CNT_W-1:0]          n_c;
  logic [CNT_W-1:0]          n2_c;
  logic signed [SUM_W-1:0]   sum_lx, sum_ly, sum_rx, sum_ry;
  logic [COORD_W-1:0]        max_l, max_r, cen_z;
  logic signed [COORD_W-1:0] cen_x, cen_y, e0_x, e0_y, e1_x, e1_y;

  assign head      = cell_q[0];
  assign head_zabs = head.z[COORD_W-1] ? COORD_W'(-head.z) : COORD_W'(head.z);
  assign n_c       = CNT_W'(half_n);
  assign n2_c      = CNT_W'({half_n, 1'b0});

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sum_lx <= '0;
      sum_ly <= '0;
      sum_rx <= '0;
      sum_ry <= '0;
      max_l  <= '0;
      max_r  <= '0;
    end else if (state == ST_ROT) begin
      if (step < n_c) begin
        sum_rx <= sum_rx + SUM_W'($signed(head.x));
        sum_ry <= sum_ry + SUM_W'($signed(head.y));
        if (head_zabs > max_r) begin
          max_r <= head_zabs;
        end
      end
      if (step > n_c && step <= n2_c) begin
        sum_lx <= sum_lx + SUM_W'($signed(head.x));
        sum_ly <= sum_ly + SUM_W'($signed(head.y));
        if (head_zabs > max_l) begin
          max_l <= head_zabs;
        end
      end
      if (step == n_c) begin
        cen_x <= head.x;
        cen_y <= head.y;
        cen_z <= head_zabs;
      end
      if (step == '0) begin
        e0_x <= head.x;
        e0_y <= head.y;
      end
      if (step == n2_c) begin
        e1_x <= head.x;
        e1_y <= head.y;
      end
    end
  end

  // side vectors, span deltas and side maxima with the centre
  logic signed [OFS_W-1:0]   n_s;
  logic signed [OFS_W-1:0]   va_x, va_y, vb_x, vb_y;
  logic signed [COORD_W:0]   d_x, d_y;
  logic [COORD_W-1:0]        hmax_l, hmax_r;

  assign n_s = OFS_W'(signed'({1'b0, half_n}));

  always_ff @(posedge clk) begin
    if (state == ST_OFFSET) begin
      va_x   <= OFS_W'(sum_lx) - n_s * OFS_W'(cen_x);
      va_y   <= OFS_W'(sum_ly) - n_s * OFS_W'(cen_y);
      vb_x   <= OFS_W'(sum_rx) - n_s * OFS_W'(cen_x);
      vb_y   <= OFS_W'(sum_ry) - n_s * OFS_W'(cen_y);
      d_x    <= (COORD_W + 1)'(e0_x) - (COORD_W + 1)'(e1_x);
      d_y    <= (COORD_W + 1)'(e0_y) - (COORD_W + 1)'(e1_y);
      hmax_l <= (max_l > cen_z) ? max_l : cen_z;
      hmax_r <= (max_r > cen_z) ? max_r : cen_z;
    end
  end

  // one product per cycle, each registered and added in the next cycle
  logic signed [OFS_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod_q;
  logic [SQ_W-1:0]          prod_k;
  logic signed [PROD_W-1:0] acc_a2, acc_b2, acc_dot, acc_sp, acc_lim;

  assign prod_k = sq_k - 1'b1;

  always_comb begin
    case (sq_k)
      SQ_A_X: begin op_a = va_x; op_b = va_x; end
      SQ_A_Y: begin op_a = va_y; op_b = va_y; end
      SQ_B_X: begin op_a = vb_x; op_b = vb_x; end
      SQ_B_Y: begin op_a = vb_y; op_b = vb_y; end
      SQ_D_X: begin op_a = va_x; op_b = vb_x; end
      SQ_D_Y: begin op_a = va_y; op_b = vb_y; end
      SQ_S_X: begin op_a = OFS_W'(d_x); op_b = OFS_W'(d_x); end
      SQ_S_Y: begin op_a = OFS_W'(d_y); op_b = OFS_W'(d_y); end
      SQ_LIM: begin
        op_a = OFS_W'(signed'({1'b0, span_limit}));
        op_b = OFS_W'(signed'({1'b0, span_limit}));
      end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_OFFSET) begin
      acc_a2  <= '0;
      acc_b2  <= '0;
      acc_dot <= '0;
      acc_sp  <= '0;
      acc_lim <= '0;
    end else if (state == ST_SQUARE) begin
      prod_q <= op_a * op_b;
      if (sq_k != SQ_A_X) begin
        case (prod_k)
          SQ_A_X, SQ_A_Y: acc_a2  <= acc_a2 + prod_q;
          SQ_B_X, SQ_B_Y: acc_b2  <= acc_b2 + prod_q;
          SQ_D_X, SQ_D_Y: acc_dot <= acc_dot + prod_q;
          SQ_S_X, SQ_S_Y: acc_sp  <= acc_sp + prod_q;
          SQ_LIM:         acc_lim <= acc_lim + prod_q;
          default: ;
        endcase
      end
    end
  end

  // wide products: dot^2, |a|^2 |b|^2, then times T^2
  logic [PROD_W-1:0]    dot_abs;
  logic signed [31:0]   t2_s;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_p;
  logic [MUL_A_W-1:0]   ab_q;
  logic [MUL_P_W-1:0]   lhs_q, rhs_q;

  assign dot_abs = acc_dot[PROD_W-1] ? PROD_W'(-acc_dot) : PROD_W'(acc_dot);
  assign t2_s    = 32'(angle_cos) * 32'(angle_cos);

  always_comb begin
    case (mul_sel)
      MSEL_DOT: begin
        mul_a = MUL_A_W'(dot_abs);
        mul_b = dot_abs[MUL_B_W-1:0];
      end
      MSEL_AB: begin
        mul_a = MUL_A_W'($unsigned(acc_a2));
        mul_b = acc_b2[MUL_B_W-1:0];
      end
      default: begin
        mul_a = ab_q;
        mul_b = MUL_B_W'($unsigned(t2_s));
      end
    endcase
  end

  lcpc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  always_ff @(posedge clk) begin
    if (state == ST_MUL_WAIT && mul_done) begin
      case (mul_sel)
        MSEL_DOT: lhs_q <= mul_p << ANGLE_SHIFT;
        MSEL_AB:  ab_q  <= mul_p[MUL_A_W-1:0];
        default:  rhs_q <= mul_p;
      endcase
    end
  end

  // decision
  logic              span_ok, vec_ok, angle_ok, height_ok, side_ok;
  logic [COORD_W-1:0] side_gap;

  always_comb begin
    span_ok = acc_sp < acc_lim;
    vec_ok  = (acc_a2 != '0) && (acc_b2 != '0);
    if (angle_cos <= 0 && !acc_dot[PROD_W-1]) begin
      angle_ok = 1'b1;
    end else if (angle_cos > 0 && (acc_dot[PROD_W-1] || acc_dot == '0)) begin
      angle_ok = 1'b0;
    end else if (angle_cos > 0) begin
      angle_ok = lhs_q >= rhs_q;
    end else begin
      angle_ok = lhs_q <= rhs_q;
    end
    height_ok = ((hmax_l - cen_z) >= COORD_W'(curb_height)) ||
                ((hmax_r - cen_z) >= COORD_W'(curb_height));
    side_gap  = (hmax_l > hmax_r) ? (hmax_l - hmax_r) : (hmax_r - hmax_l);
    side_ok   = side_gap >= COORD_W'(side_diff);
    curb_flag = span_ok && vec_ok && angle_ok && height_ok && side_ok;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      center_index <= center_q;
      is_curb      <= curb_flag;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcpc_cell.sv =====
// ----------------------------------------------------------------------------
// lcpc_cell: one window cell
// Holds one point; loads from the newer-side neighbor on a new transfer or
// from the older-side neighbor while the window rotates past the head.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpc_cell import lcpc_pkg::*; (
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire point_t     shift_in,
  input  wire point_t     rot_in,
  output point_t          data
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= shift_in;
    end else if (ctrl.rotate) begin
      data <= rot_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcpc_mul.sv =====
// ----------------------------------------------------------------------------
// lcpc_mul: iterative unsigned multiplier
// Shift-add, one bit of b per cycle; done pulses when product is final.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpc_mul import lcpc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic                    done,
  output logic [MUL_P_W-1:0]      product
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [MUL_P_W-1:0]   a_sh;
  logic [MUL_B_W-1:0]   b_sh;
  logic [MUL_P_W-1:0]   acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= MUL_P_W'(a);
      b_sh <= b;
      acc  <= '0;
    end else if (busy) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

  assign product = acc;

endmodule

`default_nettype wire

// ===== rtl/lcpc_checker.sv =====
// ----------------------------------------------------------------------------
// lcpc_checker: port-level assertions for the curb point classifier
// Reset behavior, result holding, and ring start / transfer timing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lcpc_checker import lcpc_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             first_of_ring,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [IDX_W-1:0] center_index,
  input wire logic             is_curb
);

  `LCPC_ASSERT_RESET(a_rst_clears_out, rst, !out_valid, "out_valid not cleared by reset")

  `LCPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(center_index) && $stable(is_curb), "stalled result changed")

  `LCPC_ASSERT_NEXT(a_ring_start_idle, in_valid && in_ready && first_of_ring, in_ready, "ring start left the block busy")

  `LCPC_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result one cycle after a transfer")

endmodule

bind lidar_curb_point_classifier lcpc_checker u_lcpc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .first_of_ring (first_of_ring),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .center_index  (center_index),
  .is_curb       (is_curb)
);

`default_nettype wire
